// ===== rtl/core/sdo_upload_client_queue_defines.svh =====
// Assertion helpers for the top-level file of this block.
`ifndef SDO_UPLOAD_CLIENT_QUEUE_DEFINES_SVH
`define SDO_UPLOAD_CLIENT_QUEUE_DEFINES_SVH
`define SUCQ_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("implication failed");
`define SUCQ_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("next-cycle check failed");
`endif

// ===== rtl/core/sdo_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sdo_pkg;
	localparam int QueueDepthDefault = 16;
	localparam logic [15:0] TimeoutDefault = 16'd50;
	localparam logic [10:0] TxBase = 11'h600;
	localparam logic [10:0] RxBase = 11'h580;
	localparam logic [31:0] AbortNoMemory = 32'h05040005;

	typedef enum logic [2:0] {
		ACT_PLAIN = 3'd0, ACT_SEG = 3'd1, ACT_MARK = 3'd2, ACT_FRAME = 3'd3, ACT_TICK = 3'd4
	} action_t;
	typedef enum logic [1:0] {
		RK_FRAME = 2'd0, RK_DATA = 2'd1, RK_DONE = 2'd2, RK_FAIL = 2'd3
	} kind_t;
	typedef enum logic [1:0] {
		ERR_BAD = 2'd0, ERR_TIMEOUT = 2'd1, ERR_CAPACITY = 2'd2, ERR_UNSUP = 2'd3
	} err_t;

	typedef struct packed {
		logic [2:0] action;
		logic [6:0] node_id;
		logic [15:0] object_index;
		logic [7:0] object_subindex;
		logic [7:0] byte_limit;
		logic [7:0] request_tag;
		logic [10:0] frame_id;
		logic [3:0] frame_length;
		logic [63:0] frame_data;
	} in_item_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [10:0] out_can_id;
		logic [63:0] out_payload;
		logic [3:0] byte_count;
		logic [7:0] total_length;
		logic [1:0] error_code;
		logic [7:0] out_tag;
		logic last;
	} out_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [6:0] node;
		logic [15:0] idx;
		logic [7:0] sub;
		logic [7:0] maxlen;
		logic [7:0] tag;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_EVAL, ST_EMIT
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic capture;
		logic evaluate;
		logic advance;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic [1:0] n_res;
		logic [1:0] sel;
	} sts_t;

	function automatic logic [63:0] byte_mask(input logic [3:0] n);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			if (4'(i) < n) m[i*8 +: 8] = 8'hFF;
		end
		return m;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/core/sdo_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sdo_dp import sdo_pkg::*; #(
	parameter int QUEUE_DEPTH = QueueDepthDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire in_item_t in_item,
	input wire logic [15:0] timeout_ms,
	input wire cmd_t cmd,
	output sts_t sts,
	output out_item_t res
);
	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	entry_t mem [QUEUE_DEPTH];
	entry_t head_q;
	in_item_t item_q;
	logic [AW-1:0] head_ptr_q;
	logic [CW-1:0] count_q;
	logic head_sent_q, toggle_q, in_seg_q;
	logic [15:0] elapsed_q;
	logic [7:0] rx_q;
	out_item_t r_q [3];
	logic [1:0] n_q;

	logic [AW-1:0] wr_ptr;
	logic [AW:0] wsum;
	logic [AW-1:0] head_next;
	assign wsum = {1'b0, head_ptr_q} + (AW+1)'(count_q);
	assign wr_ptr = (wsum >= (AW+1)'(QUEUE_DEPTH)) ? AW'(wsum - (AW+1)'(QUEUE_DEPTH))
		: AW'(wsum);
	assign head_next = (head_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_ptr_q + AW'(1);

	logic is_req;
	assign is_req = item_q.action == ACT_PLAIN || item_q.action == ACT_SEG
		|| item_q.action == ACT_MARK;

	// The head entry is fetched through a registered read port.
	always_ff @(posedge clk) begin
		if (cmd.capture && (in_item.action == ACT_PLAIN || in_item.action == ACT_SEG
				|| in_item.action == ACT_MARK) && count_q < CW'(QUEUE_DEPTH)) begin
			mem[wr_ptr] <= '{kind: in_item.action[1:0],
				node: (in_item.action == ACT_MARK) ? '0 : in_item.node_id,
				idx: (in_item.action == ACT_MARK) ? '0 : in_item.object_index,
				sub: (in_item.action == ACT_MARK) ? '0 : in_item.object_subindex,
				maxlen: (in_item.action == ACT_SEG) ? in_item.byte_limit : '0,
				tag: in_item.request_tag};
		end
		head_q <= mem[head_ptr_q];
		if (cmd.capture) item_q <= in_item;
	end

	out_item_t r [3];
	logic [1:0] n;
	logic pop, set_sent, set_seg, flip, clr_el, inc_el;
	logic [7:0] new_rx;
	logic [63:0] data, abrt;
	logic [7:0] c;
	logic [3:0] len, take, dl;
	logic [8:0] sum;
	logic [10:0] tx_id;

	always_comb begin
		r[0] = '0; r[1] = '0; r[2] = '0;
		n = 2'd0;
		pop = 1'b0; set_sent = 1'b0; set_seg = 1'b0; flip = 1'b0;
		clr_el = 1'b0; inc_el = 1'b0; new_rx = rx_q;
		len = (item_q.frame_length > 4'd8) ? 4'd8 : item_q.frame_length;
		data = item_q.frame_data & byte_mask(len);
		c = data[7:0];
		tx_id = TxBase + 11'(head_q.node);
		abrt = {AbortNoMemory, head_q.sub, head_q.idx, 8'h80};
		take = '0; dl = '0; sum = '0;
		for (int i = 0; i < 3; i++) r[i].out_tag = head_q.tag;
		if (!is_req && count_q != '0) begin
			if (item_q.action == ACT_TICK) begin
				if (head_q.kind == ACT_MARK[1:0]) begin
					r[0].result_kind = RK_DONE; n = 2'd1; pop = 1'b1;
				end else if (!head_sent_q) begin
					r[0].result_kind = RK_FRAME; r[0].out_can_id = tx_id;
					r[0].out_payload = {32'h0, head_q.sub, head_q.idx, 8'h40};
					n = 2'd1; set_sent = 1'b1; clr_el = 1'b1;
				end else begin
					inc_el = 1'b1;
					if (((elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1)
							>= timeout_ms) begin
						r[0].result_kind = RK_FAIL; r[0].total_length = rx_q;
						r[0].error_code = ERR_TIMEOUT; n = 2'd1; pop = 1'b1;
					end
				end
			end else if (item_q.action == ACT_FRAME && head_sent_q
					&& head_q.kind != ACT_MARK[1:0]
					&& item_q.frame_id == RxBase + 11'(head_q.node)) begin
				if (!in_seg_q) begin
					if (c[7:5] != 3'b010) begin
						r[0].result_kind = RK_FAIL; r[0].error_code = ERR_BAD;
						n = 2'd1; pop = 1'b1;
					end else if (c[1]) begin
						take = c[0] ? 4'd4 - {2'b0, c[3:2]} : 4'd4;
						if (head_q.kind == ACT_SEG[1:0] && {4'b0, take} > head_q.maxlen)
							take = head_q.maxlen[3:0];
						r[0].result_kind = RK_DATA;
						r[0].out_payload = {32'h0, data[63:32]} & byte_mask(take);
						r[0].byte_count = take; r[0].total_length = {4'b0, take};
						r[1].result_kind = RK_DONE; r[1].total_length = {4'b0, take};
						n = 2'd2; pop = 1'b1;
					end else if (head_q.kind == ACT_PLAIN[1:0]) begin
						r[0].result_kind = RK_FRAME; r[0].out_can_id = tx_id;
						r[0].out_payload = abrt;
						r[1].result_kind = RK_FAIL; r[1].error_code = ERR_UNSUP;
						n = 2'd2; pop = 1'b1;
					end else begin
						set_seg = 1'b1; new_rx = '0; clr_el = 1'b1;
						r[0].result_kind = RK_FRAME; r[0].out_can_id = tx_id;
						r[0].out_payload = 64'h60; n = 2'd1;
					end
				end else begin
					if (c[7:5] != 3'b000 || c[4] != toggle_q) begin
						r[0].result_kind = RK_FAIL; r[0].total_length = rx_q;
						r[0].error_code = ERR_BAD; n = 2'd1; pop = 1'b1;
					end else begin
						dl = 4'd7 - {1'b0, c[3:1]};
						sum = {1'b0, rx_q} + 9'(dl);
						take = (sum > {1'b0, head_q.maxlen}) ? 4'(head_q.maxlen - rx_q) : dl;
						new_rx = rx_q + 8'(take);
						r[0].result_kind = RK_DATA;
						r[0].out_payload = (data >> 8) & byte_mask(take);
						r[0].byte_count = take; r[0].total_length = new_rx;
						n = 2'd2;
						if (c[0]) begin
							r[1].result_kind = RK_DONE; r[1].total_length = new_rx;
							pop = 1'b1;
						end else if (new_rx == head_q.maxlen) begin
							r[1].result_kind = RK_FRAME; r[1].out_can_id = tx_id;
							r[1].out_payload = abrt;
							r[2].result_kind = RK_FAIL; r[2].total_length = new_rx;
							r[2].error_code = ERR_CAPACITY; n = 2'd3; pop = 1'b1;
						end else begin
							flip = 1'b1; clr_el = 1'b1;
							r[1].result_kind = RK_FRAME; r[1].out_can_id = tx_id;
							r[1].out_payload = {59'h0, ~toggle_q, 4'h0} | 64'h60;
						end
					end
				end
			end
		end
		if (n != 2'd0) r[n - 2'd1].last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_ptr_q <= '0; count_q <= '0; head_sent_q <= 1'b0; toggle_q <= 1'b0;
			in_seg_q <= 1'b0; elapsed_q <= '0; rx_q <= '0; n_q <= '0;
		end else if (cmd.evaluate) begin
			n_q <= n;
			if (is_req) begin
				if (count_q < CW'(QUEUE_DEPTH)) count_q <= count_q + CW'(1);
			end else if (pop) begin
				head_ptr_q <= head_next; count_q <= count_q - CW'(1);
				head_sent_q <= 1'b0; elapsed_q <= '0; rx_q <= '0;
				toggle_q <= 1'b0; in_seg_q <= 1'b0;
			end else begin
				if (set_sent) head_sent_q <= 1'b1;
				if (set_seg) begin in_seg_q <= 1'b1; toggle_q <= 1'b0; end
				if (flip) toggle_q <= ~toggle_q;
				if (clr_el) elapsed_q <= '0;
				else if (inc_el && elapsed_q != 16'hFFFF) elapsed_q <= elapsed_q + 16'd1;
				rx_q <= new_rx;
			end
		end
	end

	// The capture command is only issued in idle, so the write pointer uses count_q directly.
	logic [1:0] sel_q;
	always_ff @(posedge clk) begin
		if (cmd.evaluate) begin
			r_q[0] <= r[0]; r_q[1] <= r[1]; r_q[2] <= r[2];
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sel_q <= '0;
		else if (cmd.evaluate) sel_q <= '0;
		else if (cmd.advance) sel_q <= sel_q + 2'd1;
	end
	assign sts.n_res = n_q;
	assign sts.sel = sel_q;
	assign res = (sel_q == 2'd0) ? r_q[0] : (sel_q == 2'd1) ? r_q[1] : r_q[2];
endmodule
`default_nettype wire

// ===== rtl/core/sdo_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sdo_ctrl import sdo_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input wire logic out_stall,
	input wire sts_t sts,
	output cmd_t cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_EVAL;
			ST_EVAL: begin
				cmd.evaluate = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.n_res == 2'd0) begin
					state_d = ST_IDLE;
				end else begin
					out_valid = 1'b1;
					if (!out_stall) begin
						cmd.advance = 1'b1;
						if (sts.sel + 2'd1 == sts.n_res) state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/core/sdo_upload_client_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// CANopen SDO upload client with a queue of QUEUE_DEPTH read requests. Each input
// beat passes the controller states for capture, queue read and evaluate, and the
// emit state then hands out up to three result beats, holding each while out_stall
// is high, or none for a beat without results. The order is set by the controller
// sequence and the single registered read port of the request queue. Input is held
// off while results drain. timeout_ms is written through its own valid/ready port,
// which is always ready; write it only while no input beat is in flight.
`include "sdo_upload_client_queue_defines.svh"
module sdo_upload_client_queue import sdo_pkg::*; #(
	parameter int QUEUE_DEPTH = QueueDepthDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire in_item_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output out_item_t out_data,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [15:0] cfg_data
);
	logic [15:0] timeout_q;
	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) timeout_q <= TimeoutDefault;
		else if (cfg_valid) timeout_q <= cfg_data;
	end

	sdo_ctrl u_ctrl (.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
		.sts, .cmd);
	sdo_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (.clk, .arst_n, .in_item(in_data),
		.timeout_ms(timeout_q), .cmd, .sts, .res(out_data));

	`SUCQ_ASSERT_IMP(a_no_accept_while_out, clk, arst_n, out_valid, in_stall)
	`SUCQ_ASSERT_NEXT(a_accept_blocks, clk, arst_n, in_valid && !in_stall, in_stall)
	`SUCQ_ASSERT_IMP(a_sel_range, clk, arst_n, out_valid, sts.sel < sts.n_res)
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import sdo_pkg::*;

	typedef struct {
		entry_t q [16];
		logic [3:0] head;
		logic [4:0] count;
		logic sent;
		logic [15:0] elapsed;
		logic [7:0] rcvd;
		logic tog;
		logic seg;
		logic [15:0] tmo;
	} client_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [15:0] cfg_data = '0;

	client_t client;
	client_t plan;
	in_item_t pending_beats[$];
	out_item_t expected_results[$];
	int send_idle = 15;
	int recv_stall = 83;
	int mismatches = 0;
	bit failed = 1'b0;

	sdo_upload_client_queue uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	function automatic logic [63:0] low_bytes(input logic [3:0] n);
		if (n >= 4'd8) return '1;
		return (64'd1 << (8 * n)) - 64'd1;
	endfunction

	function automatic out_item_t mk(input kind_t k, input logic [10:0] id,
			input logic [63:0] p, input logic [3:0] cnt, input logic [7:0] tot,
			input err_t e, input logic [7:0] tag);
		out_item_t r;
		r.result_kind = k;
		r.out_can_id = id;
		r.out_payload = p;
		r.byte_count = cnt;
		r.total_length = tot;
		r.error_code = e;
		r.out_tag = tag;
		r.last = 1'b0;
		return r;
	endfunction

	function automatic void pop_head(inout client_t s);
		s.head = s.head + 4'd1;
		if (s.count != 0) s.count = s.count - 5'd1;
		s.sent = 1'b0;
		s.elapsed = '0;
		s.rcvd = '0;
		s.tog = 1'b0;
		s.seg = 1'b0;
	endfunction

	function automatic void clear_client(inout client_t s);
		foreach (s.q[i]) s.q[i] = '0;
		s.head = '0;
		s.count = '0;
		s.sent = 1'b0;
		s.elapsed = '0;
		s.rcvd = '0;
		s.tog = 1'b0;
		s.seg = 1'b0;
		s.tmo = TimeoutDefault;
	endfunction

	function automatic void step_client(inout client_t s, input in_item_t it,
			inout out_item_t res[$]);
		entry_t e;
		logic [63:0] data;
		logic [63:0] abort_p;
		logic [3:0] len;
		logic [7:0] c;
		logic [7:0] take;
		logic [7:0] dl;
		logic [10:0] txid;
		res.delete();
		if (it.action <= ACT_MARK) begin
			if (s.count < 5'd16) begin
				e.kind = it.action[1:0];
				e.node = (it.action == ACT_MARK) ? '0 : it.node_id;
				e.idx = (it.action == ACT_MARK) ? '0 : it.object_index;
				e.sub = (it.action == ACT_MARK) ? '0 : it.object_subindex;
				e.maxlen = (it.action == ACT_SEG) ? it.byte_limit : '0;
				e.tag = it.request_tag;
				s.q[s.head + s.count[3:0]] = e;
				s.count = s.count + 5'd1;
			end
			return;
		end
		if (it.action > ACT_TICK || s.count == 0) return;
		e = s.q[s.head];
		txid = TxBase + {4'b0, e.node};
		abort_p = {AbortNoMemory, e.sub, e.idx, 8'h80};
		if (it.action == ACT_TICK) begin
			if (e.kind == ACT_MARK[1:0]) begin
				res.push_back(mk(RK_DONE, '0, '0, '0, '0, ERR_BAD, e.tag));
				pop_head(s);
			end else if (!s.sent) begin
				res.push_back(mk(RK_FRAME, txid, {32'b0, e.sub, e.idx, 8'h40}, '0, '0,
					ERR_BAD, e.tag));
				s.sent = 1'b1;
				s.elapsed = '0;
			end else begin
				if (s.elapsed != 16'hFFFF) s.elapsed = s.elapsed + 16'd1;
				if (s.elapsed >= s.tmo) begin
					res.push_back(mk(RK_FAIL, '0, '0, '0, s.rcvd, ERR_TIMEOUT, e.tag));
					pop_head(s);
				end
			end
		end else begin
			if (!s.sent || e.kind == ACT_MARK[1:0]) return;
			if (it.frame_id != RxBase + {4'b0, e.node}) return;
			len = (it.frame_length > 4'd8) ? 4'd8 : it.frame_length;
			data = it.frame_data & low_bytes(len);
			c = data[7:0];
			if (!s.seg) begin
				if (c[7:5] != 3'b010) begin
					res.push_back(mk(RK_FAIL, '0, '0, '0, '0, ERR_BAD, e.tag));
					pop_head(s);
				end else if (c[1]) begin
					take = c[0] ? 8'd4 - {6'b0, c[3:2]} : 8'd4;
					if (e.kind == ACT_SEG[1:0] && take > e.maxlen) take = e.maxlen;
					s.rcvd = take;
					res.push_back(mk(RK_DATA, '0, (data >> 32) & low_bytes(take[3:0]),
						take[3:0], take, ERR_BAD, e.tag));
					res.push_back(mk(RK_DONE, '0, '0, '0, take, ERR_BAD, e.tag));
					pop_head(s);
				end else if (e.kind == ACT_PLAIN[1:0]) begin
					res.push_back(mk(RK_FRAME, txid, abort_p, '0, '0, ERR_BAD, e.tag));
					res.push_back(mk(RK_FAIL, '0, '0, '0, '0, ERR_UNSUP, e.tag));
					pop_head(s);
				end else begin
					s.seg = 1'b1;
					s.tog = 1'b0;
					s.rcvd = '0;
					s.elapsed = '0;
					res.push_back(mk(RK_FRAME, txid, 64'h60, '0, '0, ERR_BAD, e.tag));
				end
			end else if (c[7:5] != 3'b000 || c[4] != s.tog) begin
				res.push_back(mk(RK_FAIL, '0, '0, '0, s.rcvd, ERR_BAD, e.tag));
				pop_head(s);
			end else begin
				dl = 8'd7 - {5'b0, c[3:1]};
				take = (({1'b0, s.rcvd} + {1'b0, dl}) > {1'b0, e.maxlen}) ?
					e.maxlen - s.rcvd : dl;
				s.rcvd = s.rcvd + take;
				res.push_back(mk(RK_DATA, '0, (data >> 8) & low_bytes(take[3:0]),
					take[3:0], s.rcvd, ERR_BAD, e.tag));
				if (c[0]) begin
					res.push_back(mk(RK_DONE, '0, '0, '0, s.rcvd, ERR_BAD, e.tag));
					pop_head(s);
				end else if (s.rcvd == e.maxlen) begin
					res.push_back(mk(RK_FRAME, txid, abort_p, '0, '0, ERR_BAD, e.tag));
					res.push_back(mk(RK_FAIL, '0, '0, '0, s.rcvd, ERR_CAPACITY, e.tag));
					pop_head(s);
				end else begin
					s.tog = ~s.tog;
					s.elapsed = '0;
					res.push_back(mk(RK_FRAME, txid, 64'h60 | {59'b0, s.tog, 4'b0}, '0, '0,
						ERR_BAD, e.tag));
				end
			end
		end
		if (res.size() > 0) res[res.size() - 1].last = 1'b1;
	endfunction

	// The plan copy runs ahead of the driver so that sequences can follow the head.
	task automatic issue(input in_item_t it);
		out_item_t scratch[$];
		step_client(plan, it, scratch);
		pending_beats.push_back(it);
	endtask

	function automatic in_item_t rand_item();
		in_item_t it;
		it.action = $urandom_range(0, 7);
		it.node_id = $urandom;
		it.object_index = $urandom;
		it.object_subindex = $urandom;
		it.byte_limit = $urandom;
		it.request_tag = $urandom;
		it.frame_id = $urandom;
		it.frame_length = $urandom_range(0, 15);
		it.frame_data = {$urandom, $urandom};
		return it;
	endfunction

	task automatic q_read(input action_t a, input logic [6:0] node, input logic [7:0] maxlen);
		in_item_t it;
		it = rand_item();
		it.action = a;
		it.node_id = node;
		it.byte_limit = maxlen;
		issue(it);
	endtask

	task automatic tick_in();
		in_item_t it;
		it = rand_item();
		it.action = ACT_TICK;
		issue(it);
	endtask

	task automatic frame_in(input logic [6:0] node, input logic [3:0] len,
			input logic [63:0] data);
		in_item_t it;
		it = rand_item();
		it.action = ACT_FRAME;
		it.frame_id = RxBase + {4'b0, node};
		it.frame_length = len;
		it.frame_data = data;
		issue(it);
	endtask

	task automatic gen_directed();
		in_item_t it;
		it = rand_item();
		it.action = ACT_PLAIN;
		it.node_id = '0;
		it.object_index = 16'hFFFF;
		it.object_subindex = 8'hFF;
		it.request_tag = 8'h00;
		issue(it);
		tick_in();
		frame_in(7'd0, 4'd8, 64'hFFFF_FFFF_0000_0043);
		q_read(ACT_PLAIN, 7'd127, 8'd0);
		tick_in();
		frame_in(7'd127, 4'd8, 64'h1234_5678_9ABC_DE40);
		// A segment that overruns the byte limit aborts with a capacity failure.
		q_read(ACT_SEG, 7'd5, 8'd3);
		tick_in();
		frame_in(7'd5, 4'd8, 64'h41);
		frame_in(7'd5, 4'd8, 64'hFFFF_FFFF_FFFF_FF00);
		q_read(ACT_MARK, 7'd0, 8'd0);
		tick_in();
		q_read(ACT_SEG, 7'd1, 8'd255);
		tick_in();
		frame_in(7'd1, 4'd12, 64'h41);
		frame_in(7'd1, 4'd8, 64'hAAAA_AAAA_AAAA_AA0E);
		frame_in(7'd1, 4'd3, 64'h5555_5555_5555_5511);
		q_read(ACT_PLAIN, 7'd2, 8'd0);
		tick_in();
		tick_in();
		tick_in();
		q_read(ACT_PLAIN, 7'd3, 8'd0);
		tick_in();
		frame_in(7'd3, 4'd8, 64'h80);
		q_read(ACT_SEG, 7'd4, 8'd0);
		tick_in();
		frame_in(7'd4, 4'd8, 64'hDEAD_BEEF_0000_0042);
	endtask

	task automatic gen_random(input int n);
		in_item_t it;
		entry_t h;
		int r;
		repeat (n) begin
			it = rand_item();
			r = $urandom_range(0, 99);
			h = plan.q[plan.head];
			if (r < 10) begin
				// Noise: anything at all, including stray frames and unknown actions.
			end else if (r < 13) begin
				// Burst of requests to run the queue into its full state.
				repeat ($urandom_range(17, 19)) begin
					it = rand_item();
					it.action = $urandom_range(0, 2);
					issue(it);
				end
				continue;
			end else if (plan.count == 0 || r < 25) begin
				it.action = $urandom_range(0, 2);
				if ($urandom_range(0, 1)) it.byte_limit = $urandom_range(0, 24);
			end else if (h.kind == ACT_MARK[1:0] || !plan.sent || r < 40) begin
				it.action = ACT_TICK;
			end else begin
				it.action = ACT_FRAME;
				it.frame_id = RxBase + {4'b0, h.node};
				if ($urandom_range(0, 3) != 0) it.frame_length = 4'd8;
				if (!plan.seg) begin
					it.frame_data[7:5] = 3'b010;
					if (h.kind == ACT_SEG[1:0] && $urandom_range(0, 9) < 6)
						it.frame_data[1] = 1'b0;
				end else begin
					it.frame_data[7:4] = {3'b000, plan.tog};
					it.frame_data[0] = ($urandom_range(0, 3) == 0);
				end
				if (r > 95) it.frame_data[7:0] = $urandom;
			end
			issue(it);
		end
	endtask

	task automatic write_timeout(input logic [15:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		client.tmo = v;
		plan.tmo = v;
	endtask

	task automatic drain();
		@(posedge clk);
		while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	always @(posedge clk) begin
		out_item_t fresh[$];
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				step_client(client, in_data, fresh);
				foreach (fresh[i]) expected_results.push_back(fresh[i]);
			end
			if (!in_valid || !in_stall) begin
				if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
					in_valid <= 1'b1;
					in_data <= pending_beats.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					failed = 1'b1;
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat: kind %0d tag %h", out_data.result_kind,
							out_data.out_tag);
				end else begin
					want = expected_results.pop_front();
					if (out_data.result_kind !== want.result_kind ||
							out_data.out_can_id !== want.out_can_id ||
							out_data.out_payload !== want.out_payload ||
							out_data.byte_count !== want.byte_count ||
							out_data.total_length !== want.total_length ||
							out_data.error_code !== want.error_code ||
							out_data.out_tag !== want.out_tag ||
							out_data.last !== want.last) begin
						failed = 1'b1;
						mismatches++;
						if (mismatches <= 10) begin
							$display("result mismatch (exp/got): kind %0d/%0d id %h/%h payload %h/%h",
								want.result_kind, out_data.result_kind,
								want.out_can_id, out_data.out_can_id,
								want.out_payload, out_data.out_payload);
							$display("  count %0d/%0d total %0d/%0d err %0d/%0d tag %h/%h last %b/%b",
								want.byte_count, out_data.byte_count,
								want.total_length, out_data.total_length,
								want.error_code, out_data.error_code,
								want.out_tag, out_data.out_tag, want.last, out_data.last);
						end
					end
				end
			end
			out_stall <= ($urandom_range(0, 99) < recv_stall);
		end
	end

	initial begin
		clear_client(client);
		clear_client(plan);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		write_timeout(16'd2);
		gen_directed();
		gen_random(35);
		drain();
		write_timeout(16'd0);
		gen_random(12);
		drain();

		send_idle = 83;
		recv_stall = 15;
		write_timeout(16'd4);
		gen_random(35);
		drain();
		write_timeout(16'd1);
		gen_random(12);
		drain();

		send_idle = 0;
		recv_stall = 0;
		write_timeout(16'hFFFF);
		gen_random(35);
		drain();

		if (expected_results.size() != 0) failed = 1'b1;
		if (!failed) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// ===== sdo_upload_client_queue.f =====
+incdir+rtl/core
rtl/core/sdo_pkg.sv
rtl/core/sdo_dp.sv
rtl/core/sdo_ctrl.sv
rtl/core/sdo_upload_client_queue.sv
tb/testbench.sv
